[rtl/srp_pkg.sv]
// Shared types and constants for the STUN response parser.
// Used by the parse core and the top level; no dependencies.
`timescale 1ns / 1ps

package srp_pkg;

  // Header geometry and the saturating byte counter.
  localparam int unsigned CntW   = 17;
  localparam logic [CntW-1:0] CntMax = 17'h1FFFF;
  localparam logic [CntW-1:0] HdrLen = 17'd20;

  // Result status codes.
  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_SHORT_HDR     = 4'd1,
    ST_BAD_TYPE      = 4'd2,
    ST_LEN_OVERRUN   = 4'd3,
    ST_ATTR_TRUNC    = 4'd4,
    ST_ATTR_OVERRUN  = 4'd5,
    ST_BAD_ADDR_LEN  = 4'd6,
    ST_BAD_FAMILY    = 4'd7,
    ST_BAD_FLAGS_LEN = 4'd8,
    ST_UNKNOWN_ATTR  = 4'd9
  } status_e;

  // Reported family of the mapped address.
  typedef enum logic [1:0] {
    MF_NONE = 2'd0,
    MF_IPV4 = 2'd1,
    MF_IPV6 = 2'd2
  } mapped_family_e;

  // Message types.
  localparam logic [15:0] MSG_BIND_REQ  = 16'h0001;
  localparam logic [15:0] MSG_BIND_RESP = 16'h0101;

  // Attribute types.
  localparam logic [15:0] ATTR_MAPPED        = 16'h0001;
  localparam logic [15:0] ATTR_RESPONSE      = 16'h0002;
  localparam logic [15:0] ATTR_FLAGS         = 16'h0003;
  localparam logic [15:0] ATTR_SOURCE        = 16'h0004;
  localparam logic [15:0] ATTR_CHANGED       = 16'h0005;
  localparam logic [15:0] ATTR_MANDATORY_MAX = 16'h7FFF;

  // Address family bytes and value lengths.
  localparam logic [7:0]  FAM_IPV4      = 8'h01;
  localparam logic [7:0]  FAM_IPV6      = 8'h02;
  localparam logic [15:0] ADDR_LEN_V4   = 16'd8;
  localparam logic [15:0] ADDR_LEN_V6   = 16'd20;
  localparam logic [15:0] FLAGS_LEN     = 16'd4;
  localparam logic [15:0] ATTR_HDR_LEN  = 16'd4;

  // One received byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  // One parse result.
  typedef struct packed {
    status_e        status;
    logic [15:0]    msg_type;
    logic [63:0]    id_high;
    logic [63:0]    id_low;
    logic [15:0]    mapped_port;
    logic [31:0]    mapped_ip;
    mapped_family_e mapped_family;
  } result_t;

  // Address-carrying attribute types.
  function automatic logic is_addr_type(input logic [15:0] t);
    is_addr_type = (t == ATTR_MAPPED) || (t == ATTR_RESPONSE) ||
                   (t == ATTR_SOURCE) || (t == ATTR_CHANGED);
  endfunction

endpackage

[rtl/srp_stream_if.sv]
// Valid/ready stream interfaces for the STUN response parser.
// srp_in_if carries received bytes, srp_out_if carries parse results.
`timescale 1ns / 1ps

interface srp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface srp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [15:0] msg_type;
  logic [63:0] id_high;
  logic [63:0] id_low;
  logic [15:0] mapped_port;
  logic [31:0] mapped_ip;
  logic [1:0]  mapped_family;

  modport source (output valid, output status, output msg_type, output id_high,
                  output id_low, output mapped_port, output mapped_ip,
                  output mapped_family, input ready);
  modport sink   (input valid, input status, input msg_type, input id_high,
                  input id_low, input mapped_port, input mapped_ip,
                  input mapped_family, output ready);
endinterface

[rtl/stun_response_parser.sv]
// The last byte of a buffer passes the input register, then the result register holds its result.
// Throughput: one byte per clock; the input stalls only while a finished result waits at the output.
// The parse itself is one pass of logic between the input register and the result register.
// Reset clears the parser state and both valid flags; the first byte after reset starts a buffer.
// Top level: input register, srp_parse_core, and the result register.
// Depends on srp_pkg and srp_stream_if.
`timescale 1ns / 1ps

module stun_response_parser (
  input  logic      clk_i,
  input  logic      rst_ni,
  srp_in_if.sink    in_i,
  srp_out_if.source out_o
);

  logic             s1_valid_q;
  srp_pkg::item_t   s1_item_q;
  logic             out_valid_q;
  srp_pkg::result_t out_res_q;
  srp_pkg::result_t core_res;
  logic             out_free;
  logic             advance;

  // The held byte moves on unless it would produce a result that has no room.
  assign out_free  = !out_valid_q || out_o.ready;
  assign advance   = s1_valid_q && (!s1_item_q.last || out_free);
  assign in_i.ready = !s1_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q <= '{data_byte: in_i.data_byte, last: in_i.last};
    end
  end

  srp_parse_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (s1_item_q),
    .result_o (core_res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && s1_item_q.last) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_item_q.last) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_res_q.status;
  assign out_o.msg_type      = out_res_q.msg_type;
  assign out_o.id_high       = out_res_q.id_high;
  assign out_o.id_low        = out_res_q.id_low;
  assign out_o.mapped_port   = out_res_q.mapped_port;
  assign out_o.mapped_ip     = out_res_q.mapped_ip;
  assign out_o.mapped_family = out_res_q.mapped_family;

  // A failed parse reports nothing but its status.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_o.status != srp_pkg::ST_OK
      |-> out_o.msg_type == '0 && out_o.mapped_family == '0 && out_o.id_high == '0)
    else $error("error result carries payload");

  // A good parse always carries a binding message type.
  a_ok_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_o.status == srp_pkg::ST_OK
      |-> out_o.msg_type == srp_pkg::MSG_BIND_REQ || out_o.msg_type == srp_pkg::MSG_BIND_RESP)
    else $error("good result with a bad message type");

  // A reported address comes with a known family and a good status.
  a_family: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_o.mapped_family != '0
      |-> out_o.status == srp_pkg::ST_OK && out_o.mapped_family != 2'd3)
    else $error("mapped family reported with a bad status or code");

  // The input stage only stalls behind a pending result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_valid_q && s1_item_q.last && out_valid_q)
    else $error("input stalled without a pending result");

endmodule

[rtl/srp_parse_core.sv]
// Parser state and per-byte update for STUN messages: header capture and attribute walk.
// Depends on srp_pkg. Produces the result for the byte being stepped.
`timescale 1ns / 1ps

module srp_parse_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  srp_pkg::item_t   item_i,
  output srp_pkg::result_t result_o
);

  logic [srp_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [15:0]              type_q, type_d;
  logic [15:0]              len_q, len_d;
  logic [63:0]              id_hi_q, id_hi_d;
  logic [63:0]              id_lo_q, id_lo_d;
  logic [15:0]              rem_q, rem_d;
  logic [15:0]              pos_q, pos_d;
  logic [15:0]              atype_q, atype_d;
  logic [15:0]              alen_q, alen_d;
  logic [15:0]              port_q, port_d;
  logic [31:0]              ip_q, ip_d;
  logic [15:0]              mport_q, mport_d;
  logic [31:0]              mip_q, mip_d;
  srp_pkg::mapped_family_e  mfam_q, mfam_d;
  srp_pkg::status_e         err_q, err_d;

  logic [7:0]               b;
  logic                     walk;
  logic                     stop;
  logic [15:0]              alen_new;
  srp_pkg::status_e         status;

  assign b = item_i.data_byte;

  // Next-state logic for one byte, then the result, then the clear on the last byte.
  always_comb begin
    cnt_d    = cnt_q;
    type_d   = type_q;
    len_d    = len_q;
    id_hi_d  = id_hi_q;
    id_lo_d  = id_lo_q;
    rem_d    = rem_q;
    pos_d    = pos_q;
    atype_d  = atype_q;
    alen_d   = alen_q;
    port_d   = port_q;
    ip_d     = ip_q;
    mport_d  = mport_q;
    mip_d    = mip_q;
    mfam_d   = mfam_q;
    err_d    = err_q;
    walk     = 1'b0;
    stop     = 1'b0;
    alen_new = alen_q;
    status   = srp_pkg::ST_OK;
    result_o = '0;

    if (step_i) begin
      if (cnt_q != srp_pkg::CntMax) begin
        cnt_d = cnt_q + 17'd1;
      end
      // Header capture by byte index.
      if (cnt_q < 17'd2) begin
        type_d = {type_q[7:0], b};
      end else if (cnt_q < 17'd4) begin
        len_d = {len_q[7:0], b};
      end else if (cnt_q < 17'd12) begin
        id_hi_d = {id_hi_q[55:0], b};
      end else if (cnt_q < srp_pkg::HdrLen) begin
        id_lo_d = {id_lo_q[55:0], b};
        if (cnt_q == srp_pkg::HdrLen - 17'd1) begin
          rem_d = len_q;
        end
      end else if (rem_q != 16'd0 && err_q == srp_pkg::ST_OK) begin
        walk = 1'b1;
      end
    end

    // Attribute walk for one body byte.
    if (walk) begin
      rem_d = rem_q - 16'd1;
      if (pos_q == 16'd0 && rem_q < srp_pkg::ATTR_HDR_LEN) begin
        err_d = srp_pkg::ST_ATTR_TRUNC;
      end else begin
        if (pos_q == 16'd2 || pos_q == 16'd3) begin
          alen_new = {alen_q[7:0], b};
        end
        alen_d = alen_new;

        priority if (pos_q < 16'd2) begin
          atype_d = {atype_q[7:0], b};
        end else if (pos_q < 16'd4) begin
          // Length bytes are taken above.
        end else if (pos_q == 16'd5 && srp_pkg::is_addr_type(atype_q)) begin
          if (b == srp_pkg::FAM_IPV4) begin
            if (alen_q != srp_pkg::ADDR_LEN_V4) begin
              err_d = srp_pkg::ST_BAD_ADDR_LEN;
              stop  = 1'b1;
            end
          end else if (b == srp_pkg::FAM_IPV6) begin
            if (alen_q != srp_pkg::ADDR_LEN_V6) begin
              err_d = srp_pkg::ST_BAD_ADDR_LEN;
              stop  = 1'b1;
            end
          end else begin
            err_d = srp_pkg::ST_BAD_FAMILY;
            stop  = 1'b1;
          end
        end else if (pos_q == 16'd6 || pos_q == 16'd7) begin
          port_d = {port_q[7:0], b};
        end else if (pos_q >= 16'd8 && pos_q <= 16'd11) begin
          ip_d = {ip_q[23:0], b};
          if (pos_q == 16'd11 && atype_q == srp_pkg::ATTR_MAPPED) begin
            mport_d = port_q;
            mip_d   = {ip_q[23:0], b};
            mfam_d  = (alen_q == srp_pkg::ADDR_LEN_V4) ? srp_pkg::MF_IPV4
                                                       : srp_pkg::MF_IPV6;
          end
        end else begin
          // Value bytes that are not reported.
        end

        // Attribute header complete: check the length against type and body.
        if (!stop && pos_q == 16'd3) begin
          if (alen_new > rem_d) begin
            err_d = srp_pkg::ST_ATTR_OVERRUN;
            stop  = 1'b1;
          end else if (srp_pkg::is_addr_type(atype_q)) begin
            if (alen_new < srp_pkg::ADDR_LEN_V4) begin
              err_d = srp_pkg::ST_BAD_ADDR_LEN;
              stop  = 1'b1;
            end
          end else if (atype_q == srp_pkg::ATTR_FLAGS) begin
            if (alen_new != srp_pkg::FLAGS_LEN) begin
              err_d = srp_pkg::ST_BAD_FLAGS_LEN;
              stop  = 1'b1;
            end
          end else if (atype_q <= srp_pkg::ATTR_MANDATORY_MAX) begin
            err_d = srp_pkg::ST_UNKNOWN_ATTR;
            stop  = 1'b1;
          end
        end

        // Advance within the attribute or start the next one.
        if (!stop) begin
          if (pos_q >= 16'd3 &&
              ({1'b0, pos_q} + 17'd1) == ({1'b0, alen_new} + 17'd4)) begin
            pos_d   = '0;
            atype_d = '0;
            alen_d  = '0;
            port_d  = '0;
            ip_d    = '0;
          end else begin
            pos_d = pos_q + 16'd1;
          end
        end
      end
    end

    // Status in priority order, from the state after this byte.
    if (cnt_d < srp_pkg::HdrLen) begin
      status = srp_pkg::ST_SHORT_HDR;
    end else if (type_d != srp_pkg::MSG_BIND_REQ && type_d != srp_pkg::MSG_BIND_RESP) begin
      status = srp_pkg::ST_BAD_TYPE;
    end else if (({2'b00, len_d} + 18'd20) > {1'b0, cnt_d}) begin
      status = srp_pkg::ST_LEN_OVERRUN;
    end else begin
      status = err_d;
    end

    result_o.status = status;
    if (status == srp_pkg::ST_OK) begin
      result_o.msg_type      = type_d;
      result_o.id_high       = id_hi_d;
      result_o.id_low        = id_lo_d;
      result_o.mapped_port   = mport_d;
      result_o.mapped_ip     = mip_d;
      result_o.mapped_family = mfam_d;
    end

    // The last byte ends the buffer: start over from the reset state.
    if (step_i && item_i.last) begin
      cnt_d   = '0;
      type_d  = '0;
      len_d   = '0;
      id_hi_d = '0;
      id_lo_d = '0;
      rem_d   = '0;
      pos_d   = '0;
      atype_d = '0;
      alen_d  = '0;
      port_d  = '0;
      ip_d    = '0;
      mport_d = '0;
      mip_d   = '0;
      mfam_d  = srp_pkg::MF_NONE;
      err_d   = srp_pkg::ST_OK;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      type_q  <= '0;
      len_q   <= '0;
      id_hi_q <= '0;
      id_lo_q <= '0;
      rem_q   <= '0;
      pos_q   <= '0;
      atype_q <= '0;
      alen_q  <= '0;
      port_q  <= '0;
      ip_q    <= '0;
      mport_q <= '0;
      mip_q   <= '0;
      mfam_q  <= srp_pkg::MF_NONE;
      err_q   <= srp_pkg::ST_OK;
    end else begin
      cnt_q   <= cnt_d;
      type_q  <= type_d;
      len_q   <= len_d;
      id_hi_q <= id_hi_d;
      id_lo_q <= id_lo_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
      atype_q <= atype_d;
      alen_q  <= alen_d;
      port_q  <= port_d;
      ip_q    <= ip_d;
      mport_q <= mport_d;
      mip_q   <= mip_d;
      mfam_q  <= mfam_d;
      err_q   <= err_d;
    end
  end

  // A stepped last byte always leaves the counter and error cleared.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.last |=> cnt_q == '0 && err_q == srp_pkg::ST_OK)
    else $error("parser state not cleared after last byte");

  // A recorded attribute error holds until the buffer ends.
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != srp_pkg::ST_OK && !(step_i && item_i.last) |=> err_q == $past(err_q))
    else $error("attribute error changed within a buffer");

  // The attribute walk never runs past the declared message length.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= len_q)
    else $error("remaining body bytes exceed message length");

endmodule
